[rtl/core/sliding_window_sender_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window sender
// Shared property forms. Each macro expects i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SENDER_ASSERT_SVH
`define SLIDING_WINDOW_SENDER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sliding window sender: check failed");

// Next-cycle implication, checked out of reset.
`define SWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sliding window sender: check failed");

`endif

[rtl/core/sws_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding window sender package
// Sizes, command codes, the command beat and helpers shared by all parts.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int MAX_SEGMENTS = 4096;
    localparam int MAX_WINDOW   = 16;
    localparam int RESET_WINDOW = 10;

    localparam int SEQ_W  = $clog2(MAX_SEGMENTS);     // sequence number
    localparam int CNT_W  = SEQ_W + 1;                // count up to MAX_SEGMENTS
    localparam int WIN_W  = $clog2(MAX_WINDOW) + 1;   // window size register
    localparam int SUM_W  = CNT_W + 1;                // base plus window
    localparam int FUNC_W = 2;

    // Command queue depth, a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Function codes of an input beat, also used as queue opcodes
    localparam logic [FUNC_W-1:0] OP_SEND = 2'd0;
    localparam logic [FUNC_W-1:0] OP_ACK  = 2'd1;
    localparam logic [FUNC_W-1:0] OP_TICK = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TOTAL  = 1'b0;
    localparam logic CFG_WINDOW = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [SEQ_W-1:0]  ack_seq;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [CNT_W-1:0] eff_total(input logic [CNT_W-1:0] t);
        if (t > CNT_W'(MAX_SEGMENTS)) begin
            return CNT_W'(MAX_SEGMENTS);
        end
        return t;
    endfunction

    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        if (w == '0) begin
            return WIN_W'(1);
        end
        if (w > WIN_W'(MAX_WINDOW)) begin
            return WIN_W'(MAX_WINDOW);
        end
        return w;
    endfunction

endpackage

[rtl/core/sliding_window_sender.sv]
// ----------------------------------------------------------------------------
// Sliding window sender: a send's command beat is queued, then run by the
// back end, whose result beat is registered; results cannot be stalled.
// An ack, or a send that leaves room in the window, ends in S_IDLE; a send
// that fills it slides via S_SLIDE_RD and S_SLIDE_CHK per acked segment.
// Timer tick: a scan in S_TICK, one retransmit per cycle at most.
// Reset: clear of the ack bitmap, busy high throughout.
// ----------------------------------------------------------------------------
module sliding_window_sender (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Command beats
    input  logic                        start,
    output logic                        busy,
    input  logic [sws_pkg::FUNC_W-1:0]  i_func,
    input  logic [sws_pkg::SEQ_W-1:0]   i_ack_seq,
    // Configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [sws_pkg::CNT_W-1:0]   i_cfg_data,
    // Result beats, one cycle each, no back-pressure
    output logic                        o_strobe,
    output logic [sws_pkg::SEQ_W-1:0]   o_seq,
    output logic                        o_resend,
    output logic                        o_all_sent,
    output logic                        o_last
);
    import sws_pkg::*;

    // Configuration registers; write them only while no command is in
    // flight. New values take effect at once.
    logic [CNT_W-1:0] r_total;
    logic [WIN_W-1:0] r_window;

    // Front to queue to back
    logic    push;
    logic    pop;
    logic    clearing;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    t_q_stat q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_window <= WIN_W'(RESET_WINDOW);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TOTAL:  r_total  <= i_cfg_data;
                CFG_WINDOW: r_window <= i_cfg_data[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Accept and classify; hold off while the bitmap clears or the queue fills
    sws_front u_front (
        .start      (start),
        .busy       (busy),
        .i_func     (i_func),
        .i_ack_seq  (i_ack_seq),
        .i_total    (r_total),
        .i_clearing (clearing),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Decouple acceptance from the multi-cycle scans in the back end
    sws_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // Execute commands in order against the bitmap and window pointers
    sws_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .i_total    (r_total),
        .i_window   (r_window),
        .o_clearing (clearing),
        .o_strobe   (o_strobe),
        .o_seq      (o_seq),
        .o_resend   (o_resend),
        .o_all_sent (o_all_sent),
        .o_last     (o_last)
    );

endmodule

[rtl/core/sws_front.sv]
// ----------------------------------------------------------------------------
// Sliding window sender front end
// Accepts command beats, drops those that cannot change state, and pushes
// the rest into the command queue.
// ----------------------------------------------------------------------------
module sws_front (
    input  logic                        start,
    output logic                        busy,
    input  logic [sws_pkg::FUNC_W-1:0]  i_func,
    input  logic [sws_pkg::SEQ_W-1:0]   i_ack_seq,
    input  logic [sws_pkg::CNT_W-1:0]   i_total,
    input  logic                        i_clearing,
    input  sws_pkg::t_q_stat            i_q_stat,
    output logic                        o_push,
    output sws_pkg::t_cmd               o_cmd
);
    import sws_pkg::*;

    logic accept;
    logic keep;

    assign busy   = i_clearing | i_q_stat.full;
    assign accept = start & ~busy;

    // Acks beyond the transfer and the unused code touch nothing: drop them
    always_comb begin
        case (i_func)
            OP_SEND: keep = 1'b1;
            OP_TICK: keep = 1'b1;
            OP_ACK:  keep = {1'b0, i_ack_seq} < eff_total(i_total);
            default: keep = 1'b0;
        endcase
    end

    assign o_push      = accept & keep;
    assign o_cmd.op      = i_func;
    assign o_cmd.ack_seq = i_ack_seq;

endmodule

[rtl/core/sws_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// Sliding window sender command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sws_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sws_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output sws_pkg::t_cmd    o_cmd,
    output sws_pkg::t_q_stat o_stat
);
    import sws_pkg::*;

    `include "sliding_window_sender_assert.svh"

    t_cmd               r_entry [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;

    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd        = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    `SWS_ASSERT_NOW(a_no_push_full, o_stat.full && !i_pop, !i_push)
    `SWS_ASSERT_NOW(a_no_pop_empty, o_stat.empty, !i_pop)
    `SWS_ASSERT_NOW(a_count_range, 1'b1, r_count <= Q_CNT_W'(Q_DEPTH))

endmodule

[rtl/core/sws_back.sv]
// ----------------------------------------------------------------------------
// Sliding window sender back end
// Owns the acknowledged bitmap and the window pointers, runs sends, acks,
// window slides and timeout scans, and drives the result beats.
// ----------------------------------------------------------------------------
module sws_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sws_pkg::t_cmd             i_cmd,
    input  sws_pkg::t_q_stat          i_q_stat,
    output logic                      o_pop,
    input  logic [sws_pkg::CNT_W-1:0] i_total,
    input  logic [sws_pkg::WIN_W-1:0] i_window,
    output logic                      o_clearing,
    output logic                      o_strobe,
    output logic [sws_pkg::SEQ_W-1:0] o_seq,
    output logic                      o_resend,
    output logic                      o_all_sent,
    output logic                      o_last
);
    import sws_pkg::*;

    `include "sliding_window_sender_assert.svh"

    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_SLIDE_RD  = 3'd2;
    localparam logic [2:0] S_SLIDE_CHK = 3'd3;
    localparam logic [2:0] S_TICK      = 3'd4;

    // Acknowledged bitmap
    logic             r_acked [MAX_SEGMENTS];
    logic             r_rdata;
    logic             mem_we;
    logic [SEQ_W-1:0] mem_wa;
    logic             mem_wd;
    logic [SEQ_W-1:0] mem_ra;

    logic [2:0]       r_state,    n_state;
    logic [SEQ_W-1:0] r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0] r_base,     n_base;
    logic [CNT_W-1:0] r_nts,      n_nts;
    logic [CNT_W-1:0] r_idx,      n_idx;
    logic [CNT_W-1:0] r_end,      n_end;
    logic             r_chk_v,    n_chk_v;
    logic [SEQ_W-1:0] r_chk_idx,  n_chk_idx;
    logic             r_pend_v,   n_pend_v;
    logic [SEQ_W-1:0] r_pend_seq, n_pend_seq;

    logic             r_out_v;
    logic [SEQ_W-1:0] r_out_seq;
    logic             r_out_resend;
    logic             r_out_all;
    logic             r_out_last;

    logic             emit;
    logic [SEQ_W-1:0] emit_seq;
    logic             emit_resend;
    logic             emit_all;
    logic             emit_last;

    logic [CNT_W-1:0] total;
    logic [SUM_W-1:0] win_end;
    logic [CNT_W-1:0] nts_inc;
    logic             can_send;
    logic [CNT_W-1:0] nts_after;

    assign total     = eff_total(i_total);
    assign win_end   = {1'b0, r_base} + SUM_W'(eff_window(i_window));
    assign nts_inc   = r_nts + 1'b1;
    assign can_send  = ({1'b0, r_nts} < win_end) && (r_nts < total);
    assign nts_after = can_send ? nts_inc : r_nts;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_base      = r_base;
        n_nts       = r_nts;
        n_idx       = r_idx;
        n_end       = r_end;
        n_chk_v     = r_chk_v;
        n_chk_idx   = r_chk_idx;
        n_pend_v    = r_pend_v;
        n_pend_seq  = r_pend_seq;
        emit        = 1'b0;
        emit_seq    = r_nts[SEQ_W-1:0];
        emit_resend = 1'b0;
        emit_all    = (r_nts >= total);
        emit_last   = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_clr_addr;
        mem_wd      = 1'b0;
        mem_ra      = r_base[SEQ_W-1:0];
        o_pop       = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SEQ_W'(MAX_SEGMENTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_SEND: begin
                            if (can_send) begin
                                emit      = 1'b1;
                                emit_all  = (nts_inc >= total);
                                emit_last = 1'b1;
                                n_nts     = nts_inc;
                            end
                            if ({1'b0, nts_after} >= win_end) begin
                                n_state = S_SLIDE_RD;
                            end
                        end
                        OP_ACK: begin
                            mem_we = 1'b1;
                            mem_wa = i_cmd.ack_seq;
                            mem_wd = 1'b1;
                        end
                        OP_TICK: begin
                            n_idx    = r_base;
                            n_end    = (win_end < {1'b0, r_nts}) ?
                                       win_end[CNT_W-1:0] : r_nts;
                            n_chk_v  = 1'b0;
                            n_pend_v = 1'b0;
                            n_state  = S_TICK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SLIDE_RD: begin
                if (r_base < r_nts) begin
                    n_state = S_SLIDE_CHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SLIDE_CHK: begin
                if (r_rdata) begin
                    n_base  = r_base + 1'b1;
                    n_state = S_SLIDE_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                // Read one bit a cycle, judge it the next; hold one hit back
                // so the final one can carry the last flag.
                mem_ra      = r_idx[SEQ_W-1:0];
                emit_resend = 1'b1;
                emit_seq    = r_pend_seq;
                if (r_idx < r_end) begin
                    n_idx     = r_idx + 1'b1;
                    n_chk_v   = 1'b1;
                    n_chk_idx = r_idx[SEQ_W-1:0];
                end else begin
                    n_chk_v = 1'b0;
                end
                if (r_chk_v && !r_rdata) begin
                    emit       = r_pend_v;
                    n_pend_v   = 1'b1;
                    n_pend_seq = r_chk_idx;
                end
                if (r_idx >= r_end && !r_chk_v) begin
                    emit      = r_pend_v;
                    emit_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_acked[mem_wa] <= mem_wd;
        end
        r_rdata <= r_acked[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_base     <= '0;
            r_nts      <= '0;
            r_chk_v    <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_base     <= n_base;
            r_nts      <= n_nts;
            r_chk_v    <= n_chk_v;
            r_pend_v   <= n_pend_v;
            r_out_v    <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_end        <= n_end;
        r_chk_idx    <= n_chk_idx;
        r_pend_seq   <= n_pend_seq;
        r_out_seq    <= emit_seq;
        r_out_resend <= emit_resend;
        r_out_all    <= emit_all;
        r_out_last   <= emit_last;
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_strobe   = r_out_v;
    assign o_seq      = r_out_seq;
    assign o_resend   = r_out_resend;
    assign o_all_sent = r_out_all;
    assign o_last     = r_out_last;

    `SWS_ASSERT_NOW(a_base_le_nts, 1'b1, r_base <= r_nts)
    `SWS_ASSERT_NOW(a_first_send_adv, r_out_v && !r_out_resend,
                    r_nts == ({1'b0, r_out_seq} + 1'b1))
    `SWS_ASSERT_NOW(a_resend_sent, r_out_v && r_out_resend, {1'b0, r_out_seq} < r_nts)
    `SWS_ASSERT_NOW(a_no_pop_clear, r_state == S_CLEAR, !o_pop)

endmodule
